>>> rtl/core/frq_pkg.sv
package frq_pkg;

    // status codes
    localparam logic [3:0] ST_POSTED     = 4'd0;
    localparam logic [3:0] ST_ADVANCED   = 4'd1;
    localparam logic [3:0] ST_FULL       = 4'd2;
    localparam logic [3:0] ST_EXHAUSTED  = 4'd3;
    localparam logic [3:0] ST_STOPPED    = 4'd4;
    localparam logic [3:0] ST_INVALID    = 4'd5;
    localparam logic [3:0] ST_ACKED      = 4'd6;
    localparam logic [3:0] ST_NOT_NEXT   = 4'd7;
    localparam logic [3:0] ST_STALE      = 4'd8;
    localparam logic [3:0] ST_UNCOVERED  = 4'd9;
    localparam logic [3:0] ST_INCOMPLETE = 4'd10;

    // item kinds
    localparam logic [1:0] KIND_POST = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // reasons, actions and completions
    localparam logic [2:0] REASON_SHUTDOWN = 3'd0;
    localparam logic [2:0] REASON_LOSS     = 3'd1;
    localparam logic [1:0] ACT_CLOSE       = 2'd0;
    localparam logic [1:0] ACT_SUBMIT      = 2'd1;
    localparam logic [1:0] ACT_WAIT        = 2'd2;
    localparam logic [1:0] CMP_CLOSED      = 2'd1;
    localparam logic [1:0] CMP_SUBMITTED   = 2'd2;

    // one input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reason;
        logic [1:0]  action;
        logic [63:0] fraw;
        logic [63:0] fseq;
        logic        sorigin;
        logic [63:0] sord;
        logic [63:0] sgen;
        logic [1:0]  completion;
        logic [63:0] craw;
        logic [63:0] cseq;
    } t_item;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic busy_item;
    } t_stat;

endpackage

>>> rtl/core/fenced_release_queue_unit.sv
// Fenced release queue: ordered events in a ring of QUEUE_DEPTH entries plus a
// sticky terminal latch, with post, terminal and acknowledge items. An item is
// captured when accepted and executed at the next edge, from which its result is
// offered. The next item is taken in the cycle its predecessor's result leaves,
// so no new item is accepted while the last one executes or its result waits;
// a stalled result holds off new input. Head fields show the state after the
// item.
module fenced_release_queue_unit #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_reason_code,
    input  logic [1:0]  i_action_code,
    input  logic [63:0] i_fence_raw,
    input  logic [63:0] i_fence_seq,
    input  logic        i_snap_origin,
    input  logic [63:0] i_snap_ordinal,
    input  logic [63:0] i_snap_generation,
    input  logic [1:0]  i_completion_code,
    input  logic [63:0] i_covered_raw,
    input  logic [63:0] i_covered_seq,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [63:0] o_posted_ordinal,
    output logic [63:0] o_posted_generation,
    output logic        o_head_valid,
    output logic        o_head_origin,
    output logic [63:0] o_head_ordinal,
    output logic [63:0] o_head_generation,
    output logic [2:0]  o_head_reason,
    output logic [1:0]  o_head_action,
    output logic [63:0] o_head_fence_raw,
    output logic [63:0] o_head_fence_seq
);
    frq_pkg::t_cmd  cmd;
    frq_pkg::t_stat stat;
    frq_pkg::t_item item;

    assign item = '{kind: i_kind, reason: i_reason_code, action: i_action_code,
                    fraw: i_fence_raw, fseq: i_fence_seq, sorigin: i_snap_origin,
                    sord: i_snap_ordinal, sgen: i_snap_generation,
                    completion: i_completion_code, craw: i_covered_raw,
                    cseq: i_covered_seq};

    frq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_stat(stat), .o_stall(o_stall), .o_valid(o_valid), .o_cmd(cmd)
    );

    frq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(item), .o_stat(stat),
        .o_status(o_status), .o_posted_ordinal(o_posted_ordinal),
        .o_posted_generation(o_posted_generation), .o_head_valid(o_head_valid),
        .o_head_origin(o_head_origin), .o_head_ordinal(o_head_ordinal),
        .o_head_generation(o_head_generation), .o_head_reason(o_head_reason),
        .o_head_action(o_head_action), .o_head_fence_raw(o_head_fence_raw),
        .o_head_fence_seq(o_head_fence_seq)
    );

    // no new item while a result waits
    a_no_take_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall) else $error("item taken over held result");
    // a taken item yields a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid) else $error("result missing");
    // a held result stays valid and its status stays stable
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)))
        else $error("held result changed");
endmodule

>>> rtl/core/frq_ctrl.sv
module frq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  frq_pkg::t_stat    i_stat,
    output logic              o_stall,
    output logic              o_valid,
    output frq_pkg::t_cmd     o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) n_state = i_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // input taken when idle or when the result leaves this cycle
    assign o_stall    = !((r_state == S_IDLE) ||
                          ((r_state == S_OUT) && !i_out_stall)) || i_stat.busy_item;
    assign o_valid    = (r_state == S_OUT);
    assign o_cmd.load = i_valid && !o_stall;
    assign o_cmd.exec = (r_state == S_EXEC);
endmodule

>>> rtl/core/frq_dp.sv
module frq_dp #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  frq_pkg::t_cmd   i_cmd,
    input  frq_pkg::t_item  i_item,
    output frq_pkg::t_stat  o_stat,
    output logic [3:0]      o_status,
    output logic [63:0]     o_posted_ordinal,
    output logic [63:0]     o_posted_generation,
    output logic            o_head_valid,
    output logic            o_head_origin,
    output logic [63:0]     o_head_ordinal,
    output logic [63:0]     o_head_generation,
    output logic [2:0]      o_head_reason,
    output logic [1:0]      o_head_action,
    output logic [63:0]     o_head_fence_raw,
    output logic [63:0]     o_head_fence_seq
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] ALL1 = '1;

    // ring storage
    logic [63:0] r_ring_ord [QUEUE_DEPTH];
    logic [63:0] r_ring_fraw[QUEUE_DEPTH];
    logic [63:0] r_ring_fseq[QUEUE_DEPTH];
    logic [4:0]  r_ring_ra  [QUEUE_DEPTH];

    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [63:0]   r_next_ord, r_last_raw, r_last_seq;
    logic          r_l_act, r_term_seen;
    logic [63:0]   r_l_ord, r_l_gen, r_l_raw, r_l_seq;
    logic [4:0]    r_l_ra;
    frq_pkg::t_item r_it;

    // registered head from ring storage
    logic [63:0] r_rh_ord, r_rh_raw, r_rh_seq;
    logic [4:0]  r_rh_ra;

    assign o_stat.busy_item = 1'b0;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
        if ({1'b0, i} + (IW+1)'(1) >= (IW+1)'(QUEUE_DEPTH)) return '0;
        return i + IW'(1);
    endfunction

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_it <= i_item;
    end

    // current head
    logic        h_valid, h_origin;
    logic [63:0] h_ord, h_gen, h_raw, h_seq;
    logic [4:0]  h_ra;
    logic        ring_has;
    always_comb begin
        ring_has = (r_count != '0);
        h_valid = ring_has; h_origin = 1'b0;
        h_ord = ring_has ? r_rh_ord : '0;
        h_gen = ring_has ? 64'd1 : '0;
        h_raw = ring_has ? r_rh_raw : '0;
        h_seq = ring_has ? r_rh_seq : '0;
        h_ra  = ring_has ? r_rh_ra : '0;
        if (r_l_act && r_l_ord != '0 && (!ring_has || r_l_ord < r_rh_ord)) begin
            h_valid = 1'b1; h_origin = 1'b1; h_ord = r_l_ord; h_gen = r_l_gen;
            h_raw = r_l_raw; h_seq = r_l_seq; h_ra = r_l_ra;
        end
    end

    // operation decode
    logic [3:0]  st;
    logic [63:0] pord, pgen, mraw, mseq;
    logic        do_post, do_new_latch, do_adv, do_ack_ring, do_ack_latch, cmp_ok;
    logic        ord_ok;
    always_comb begin
        st = frq_pkg::ST_INVALID; pord = '0; pgen = '0;
        do_post = 1'b0; do_new_latch = 1'b0; do_adv = 1'b0;
        do_ack_ring = 1'b0; do_ack_latch = 1'b0;
        ord_ok = (r_next_ord != '0) && (r_next_ord != ALL1);
        mraw = (r_it.fraw > r_last_raw) ? r_it.fraw : r_last_raw;
        mseq = (r_it.fseq > r_last_seq) ? r_it.fseq : r_last_seq;
        case (h_ra[1:0])
            frq_pkg::ACT_CLOSE: cmp_ok = (r_it.completion == frq_pkg::CMP_CLOSED) ||
                                         (r_it.completion == frq_pkg::CMP_SUBMITTED);
            frq_pkg::ACT_SUBMIT, frq_pkg::ACT_WAIT:
                cmp_ok = (r_it.completion == frq_pkg::CMP_SUBMITTED);
            default: cmp_ok = 1'b0;
        endcase
        case (r_it.kind)
            frq_pkg::KIND_POST: begin
                if (r_term_seen) st = frq_pkg::ST_STOPPED;
                else if (r_it.reason == frq_pkg::REASON_SHUTDOWN ||
                         r_it.reason == frq_pkg::REASON_LOSS ||
                         r_it.fraw < r_last_raw || r_it.fseq < r_last_seq)
                    st = frq_pkg::ST_INVALID;
                else if (r_count >= CW'(QUEUE_DEPTH)) st = frq_pkg::ST_FULL;
                else if (!ord_ok) st = frq_pkg::ST_EXHAUSTED;
                else begin
                    st = frq_pkg::ST_POSTED; pord = r_next_ord; pgen = 64'd1;
                    do_post = 1'b1;
                end
            end
            frq_pkg::KIND_TERM: begin
                if (r_it.reason > frq_pkg::REASON_LOSS) st = frq_pkg::ST_INVALID;
                else if (r_term_seen && !r_l_act) st = frq_pkg::ST_STOPPED;
                else if (r_l_act) begin
                    if (r_l_gen == ALL1) st = frq_pkg::ST_EXHAUSTED;
                    else begin
                        st = frq_pkg::ST_ADVANCED; pord = r_l_ord;
                        pgen = r_l_gen + 64'd1; do_adv = 1'b1;
                    end
                end else if (!ord_ok) st = frq_pkg::ST_EXHAUSTED;
                else begin
                    st = frq_pkg::ST_POSTED; pord = r_next_ord; pgen = 64'd1;
                    do_new_latch = 1'b1;
                end
            end
            frq_pkg::KIND_ACK: begin
                if (r_it.sord == '0) st = frq_pkg::ST_INVALID;
                else if (!h_valid || h_origin != r_it.sorigin || h_ord != r_it.sord)
                    st = frq_pkg::ST_NOT_NEXT;
                else if (h_gen != r_it.sgen || h_ra != {r_it.reason, r_it.action} ||
                         h_raw != r_it.fraw || h_seq != r_it.fseq)
                    st = frq_pkg::ST_STALE;
                else if ((h_raw != '0 && r_it.craw < h_raw) ||
                         (h_seq != '0 && r_it.cseq < h_seq))
                    st = frq_pkg::ST_UNCOVERED;
                else if (!cmp_ok) st = frq_pkg::ST_INCOMPLETE;
                else begin
                    st = frq_pkg::ST_ACKED;
                    do_ack_ring = !h_origin; do_ack_latch = h_origin;
                end
            end
            default: st = frq_pkg::ST_INVALID;
        endcase
    end

    // ring memory write and registered head read
    logic [IW-1:0] hd_next;
    logic          ring_w;
    assign ring_w  = i_cmd.exec && do_post;
    assign hd_next = (i_cmd.exec && do_ack_ring) ? inc_idx(r_head) : r_head;
    always_ff @(posedge i_clk) begin
        if (ring_w) begin
            r_ring_ord[r_tail]  <= r_next_ord;
            r_ring_fraw[r_tail] <= r_it.fraw;
            r_ring_fseq[r_tail] <= r_it.fseq;
            r_ring_ra[r_tail]   <= {r_it.reason, r_it.action};
        end
        // read head, bypass a write into the empty ring
        if (ring_w && r_count == '0) begin
            r_rh_ord <= r_next_ord; r_rh_raw <= r_it.fraw;
            r_rh_seq <= r_it.fseq;  r_rh_ra <= {r_it.reason, r_it.action};
        end else if (ring_w && r_count == CW'(1) && do_ack_ring) begin
            r_rh_ord <= r_next_ord; r_rh_raw <= r_it.fraw;
            r_rh_seq <= r_it.fseq;  r_rh_ra <= {r_it.reason, r_it.action};
        end else begin
            r_rh_ord <= r_ring_ord[hd_next]; r_rh_raw <= r_ring_fraw[hd_next];
            r_rh_seq <= r_ring_fseq[hd_next]; r_rh_ra <= r_ring_ra[hd_next];
        end
    end

    // control and latch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_next_ord <= 64'd1; r_last_raw <= '0; r_last_seq <= '0;
            r_l_act <= 1'b0; r_l_ord <= '0; r_l_gen <= '0; r_l_raw <= '0;
            r_l_seq <= '0; r_l_ra <= '0; r_term_seen <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= hd_next;
            if (do_post) begin
                r_tail <= inc_idx(r_tail);
                r_count <= r_count + CW'(1);
                r_next_ord <= r_next_ord + 64'd1;
                r_last_raw <= r_it.fraw; r_last_seq <= r_it.fseq;
            end
            if (do_ack_ring) r_count <= r_count - CW'(1);
            if (do_new_latch) begin
                r_next_ord <= r_next_ord + 64'd1;
                r_l_ord <= r_next_ord; r_l_ra <= {r_it.reason, frq_pkg::ACT_SUBMIT};
                r_l_raw <= mraw; r_l_seq <= mseq; r_l_gen <= 64'd1; r_l_act <= 1'b1;
                r_last_raw <= mraw; r_last_seq <= mseq; r_term_seen <= 1'b1;
            end
            if (do_adv) begin
                r_l_gen <= r_l_gen + 64'd1;
                r_l_raw <= (r_l_raw > mraw) ? r_l_raw : mraw;
                r_l_seq <= (r_l_seq > mseq) ? r_l_seq : mseq;
                if (r_it.reason == frq_pkg::REASON_LOSS)
                    r_l_ra <= {frq_pkg::REASON_LOSS, r_l_ra[1:0]};
                r_last_raw <= mraw; r_last_seq <= mseq; r_term_seen <= 1'b1;
            end
            if (do_ack_latch) begin
                r_l_act <= 1'b0; r_l_ord <= '0; r_l_gen <= '0;
                r_l_raw <= '0; r_l_seq <= '0; r_l_ra <= '0;
            end
        end
    end

    // result register, head is taken from state after the step
    logic [3:0]  r_st;
    logic [63:0] r_pord, r_pgen;
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st <= st; r_pord <= pord; r_pgen <= pgen;
        end
    end

    assign o_status            = r_st;
    assign o_posted_ordinal    = r_pord;
    assign o_posted_generation = r_pgen;
    assign o_head_valid        = h_valid;
    assign o_head_origin       = h_origin;
    assign o_head_ordinal      = h_ord;
    assign o_head_generation   = h_gen;
    assign o_head_reason       = h_ra[4:2];
    assign o_head_action       = h_ra[1:0];
    assign o_head_fence_raw    = h_raw;
    assign o_head_fence_seq    = h_seq;
endmodule

>>> tb/tb_fenced_release_queue_unit.sv
module tb_fenced_release_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = 8;
    localparam int RANDOM_ITEMS  = 700;
    localparam int TERM_START    = 560;
    localparam int DRAIN_AT      = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // one result item
    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] pord;
        logic [63:0] pgen;
        logic        hvalid;
        logic        horigin;
        logic [63:0] hord;
        logic [63:0] hgen;
        logic [2:0]  hreason;
        logic [1:0]  haction;
        logic [63:0] hfraw;
        logic [63:0] hfseq;
    } t_result;

    // directed row: item plus an optional hand-typed status
    typedef struct {
        frq_pkg::t_item item;
        bit             typed;
        logic [3:0]     status;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    frq_pkg::t_item drv;
    logic           o_valid;
    logic           i_stall;
    t_result        dut_res;

    fenced_release_queue_unit #(.QUEUE_DEPTH(RING_DEPTH)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (drv.kind),
        .i_reason_code     (drv.reason),
        .i_action_code     (drv.action),
        .i_fence_raw       (drv.fraw),
        .i_fence_seq       (drv.fseq),
        .i_snap_origin     (drv.sorigin),
        .i_snap_ordinal    (drv.sord),
        .i_snap_generation (drv.sgen),
        .i_completion_code (drv.completion),
        .i_covered_raw     (drv.craw),
        .i_covered_seq     (drv.cseq),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (dut_res.status),
        .o_posted_ordinal  (dut_res.pord),
        .o_posted_generation(dut_res.pgen),
        .o_head_valid      (dut_res.hvalid),
        .o_head_origin     (dut_res.horigin),
        .o_head_ordinal    (dut_res.hord),
        .o_head_generation (dut_res.hgen),
        .o_head_reason     (dut_res.hreason),
        .o_head_action     (dut_res.haction),
        .o_head_fence_raw  (dut_res.hfraw),
        .o_head_fence_seq  (dut_res.hfseq)
    );

    // shadow state of the queue
    logic [63:0] sh_ord   [RING_DEPTH];
    logic [63:0] sh_fraw  [RING_DEPTH];
    logic [63:0] sh_fseq  [RING_DEPTH];
    logic [2:0]  sh_reason[RING_DEPTH];
    logic [1:0]  sh_action[RING_DEPTH];
    int          sh_head, sh_tail, sh_count;
    logic [63:0] sh_next, sh_wl_raw, sh_wl_seq;
    logic        lt_active, sh_term_seen;
    logic [63:0] lt_ord, lt_gen, lt_fraw, lt_fseq;
    logic [2:0]  lt_reason;
    logic [1:0]  lt_action;

    t_result     pending_results[$];
    bit          row_typed;
    logic [3:0]  row_status;
    int          mismatches;
    int          idle_cycles;
    int          stall_left;
    bit          drain_wait;

    function automatic logic [63:0] max_u64(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    // current head snapshot, ring wins on equal ordinals
    function automatic t_result head_snapshot();
        t_result h;
        h = '0;
        if (sh_count != 0) begin
            h.hvalid  = 1'b1;
            h.hord    = sh_ord[sh_head];
            h.hgen    = 64'd1;
            h.hreason = sh_reason[sh_head];
            h.haction = sh_action[sh_head];
            h.hfraw   = sh_fraw[sh_head];
            h.hfseq   = sh_fseq[sh_head];
        end
        if (lt_active && lt_ord != 0 && (!h.hvalid || lt_ord < h.hord)) begin
            h.hvalid  = 1'b1;
            h.horigin = 1'b1;
            h.hord    = lt_ord;
            h.hgen    = lt_gen;
            h.hreason = lt_reason;
            h.haction = lt_action;
            h.hfraw   = lt_fraw;
            h.hfseq   = lt_fseq;
        end
        return h;
    endfunction

    function automatic bit completion_meets(logic [1:0] act, logic [1:0] cmp);
        if (act == frq_pkg::ACT_CLOSE)
            return cmp == frq_pkg::CMP_CLOSED || cmp == frq_pkg::CMP_SUBMITTED;
        if (act == frq_pkg::ACT_SUBMIT || act == frq_pkg::ACT_WAIT)
            return cmp == frq_pkg::CMP_SUBMITTED;
        return 1'b0;
    endfunction

    function automatic void release_reset();
        sh_head = 0; sh_tail = 0; sh_count = 0;
        sh_next = 64'd1; sh_wl_raw = '0; sh_wl_seq = '0;
        lt_active = 1'b0; sh_term_seen = 1'b0;
        lt_ord = '0; lt_gen = '0; lt_fraw = '0; lt_fseq = '0;
        lt_reason = '0; lt_action = '0;
    endfunction

    // apply one item to the shadow state and return its result
    function automatic t_result release_step(frq_pkg::t_item it);
        t_result     r, h;
        logic [63:0] o, fr, fs;
        r = '0;
        r.status = frq_pkg::ST_INVALID;
        fr = it.fraw;
        fs = it.fseq;
        case (it.kind)
            frq_pkg::KIND_POST: begin
                if (sh_term_seen) begin
                    r.status = frq_pkg::ST_STOPPED;
                end else if (it.reason < 3'd2 || fr < sh_wl_raw || fs < sh_wl_seq) begin
                    r.status = frq_pkg::ST_INVALID;
                end else if (sh_count >= RING_DEPTH) begin
                    r.status = frq_pkg::ST_FULL;
                end else if (sh_next == 64'd0 || sh_next == ALL_ONES) begin
                    r.status = frq_pkg::ST_EXHAUSTED;
                end else begin
                    o = sh_next;
                    sh_next = sh_next + 64'd1;
                    sh_ord[sh_tail]    = o;
                    sh_fraw[sh_tail]   = fr;
                    sh_fseq[sh_tail]   = fs;
                    sh_reason[sh_tail] = it.reason;
                    sh_action[sh_tail] = it.action;
                    sh_tail  = (sh_tail + 1) % RING_DEPTH;
                    sh_count = sh_count + 1;
                    sh_wl_raw = fr;
                    sh_wl_seq = fs;
                    r.status = frq_pkg::ST_POSTED;
                    r.pord = o;
                    r.pgen = 64'd1;
                end
            end
            frq_pkg::KIND_TERM: begin
                if (it.reason > frq_pkg::REASON_LOSS) begin
                    r.status = frq_pkg::ST_INVALID;
                end else if (sh_term_seen && !lt_active) begin
                    r.status = frq_pkg::ST_STOPPED;
                end else begin
                    fr = max_u64(fr, sh_wl_raw);
                    fs = max_u64(fs, sh_wl_seq);
                    if (lt_active) begin
                        if (lt_gen == ALL_ONES) begin
                            r.status = frq_pkg::ST_EXHAUSTED;
                        end else begin
                            lt_gen  = lt_gen + 64'd1;
                            lt_fraw = max_u64(lt_fraw, fr);
                            lt_fseq = max_u64(lt_fseq, fs);
                            if (it.reason == frq_pkg::REASON_LOSS)
                                lt_reason = frq_pkg::REASON_LOSS;
                            sh_wl_raw = fr;
                            sh_wl_seq = fs;
                            sh_term_seen = 1'b1;
                            r.status = frq_pkg::ST_ADVANCED;
                            r.pord = lt_ord;
                            r.pgen = lt_gen;
                        end
                    end else if (sh_next == 64'd0 || sh_next == ALL_ONES) begin
                        r.status = frq_pkg::ST_EXHAUSTED;
                    end else begin
                        lt_ord    = sh_next;
                        sh_next   = sh_next + 64'd1;
                        lt_reason = it.reason;
                        lt_action = frq_pkg::ACT_SUBMIT;
                        lt_fraw   = fr;
                        lt_fseq   = fs;
                        lt_gen    = 64'd1;
                        lt_active = 1'b1;
                        sh_wl_raw = fr;
                        sh_wl_seq = fs;
                        sh_term_seen = 1'b1;
                        r.status = frq_pkg::ST_POSTED;
                        r.pord = lt_ord;
                        r.pgen = 64'd1;
                    end
                end
            end
            frq_pkg::KIND_ACK: begin
                h = head_snapshot();
                if (it.sord == 64'd0) begin
                    r.status = frq_pkg::ST_INVALID;
                end else if (!h.hvalid || h.horigin != it.sorigin || h.hord != it.sord) begin
                    r.status = frq_pkg::ST_NOT_NEXT;
                end else if (h.hgen != it.sgen || h.hreason != it.reason ||
                             h.haction != it.action || h.hfraw != fr || h.hfseq != fs) begin
                    r.status = frq_pkg::ST_STALE;
                end else if ((h.hfraw != 64'd0 && it.craw < h.hfraw) ||
                             (h.hfseq != 64'd0 && it.cseq < h.hfseq)) begin
                    r.status = frq_pkg::ST_UNCOVERED;
                end else if (!completion_meets(h.haction, it.completion)) begin
                    r.status = frq_pkg::ST_INCOMPLETE;
                end else begin
                    if (!h.horigin) begin
                        sh_head  = (sh_head + 1) % RING_DEPTH;
                        sh_count = sh_count - 1;
                    end else begin
                        lt_active = 1'b0;
                        lt_ord = '0; lt_gen = '0; lt_fraw = '0; lt_fseq = '0;
                        lt_reason = '0; lt_action = '0;
                    end
                    r.status = frq_pkg::ST_ACKED;
                end
            end
            default: r.status = frq_pkg::ST_INVALID;
        endcase
        h = head_snapshot();
        r.hvalid  = h.hvalid;
        r.horigin = h.horigin;
        r.hord    = h.hord;
        r.hgen    = h.hgen;
        r.hreason = h.hreason;
        r.haction = h.haction;
        r.hfraw   = h.hfraw;
        r.hfseq   = h.hfseq;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result check and item capture at the rising edge
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", dut_res);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r !== dut_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", exp_r, dut_res);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                exp_r = release_step(drv);
                if (row_typed)
                    exp_r.status = row_status;
                pending_results.push_back(exp_r);
            end
        end
    end

    // receiver stall, redrawn per result item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (o_valid && !i_stall) begin
            stall_left = drain_wait ? 0 : $urandom_range(0, 10);
            i_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // send one item after a gap, hold it until accepted
    task automatic send_item(frq_pkg::t_item it, int gap, bit typed, logic [3:0] st);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv        <= it;
        row_typed  <= typed;
        row_status <= st;
        i_valid    <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic frq_pkg::t_item ack_of(t_result h, logic [1:0] cmp);
        frq_pkg::t_item a;
        a = '0;
        a.kind    = frq_pkg::KIND_ACK;
        a.sorigin = h.horigin;
        a.sord    = h.hord;
        a.sgen    = h.hgen;
        a.reason  = h.hreason;
        a.action  = h.haction;
        a.fraw    = h.hfraw;
        a.fseq    = h.hfseq;
        a.craw    = (h.hfraw == ALL_ONES) ? h.hfraw : h.hfraw + 64'($urandom_range(0, 3));
        a.cseq    = (h.hfseq == ALL_ONES) ? h.hfseq : h.hfseq + 64'($urandom_range(0, 3));
        a.completion = cmp;
        return a;
    endfunction

    function automatic frq_pkg::t_item noise_item();
        frq_pkg::t_item n;
        n.kind       = 2'($urandom);
        n.reason     = 3'($urandom);
        n.action     = 2'($urandom);
        n.fraw       = {$urandom, $urandom};
        n.fseq       = {$urandom, $urandom};
        n.sorigin    = 1'($urandom);
        n.sord       = {$urandom, $urandom};
        n.sgen       = {$urandom, $urandom};
        n.completion = 2'($urandom);
        n.craw       = {$urandom, $urandom};
        n.cseq       = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                n.kind = frq_pkg::KIND_POST;
                n.reason = 3'($urandom_range(0, 1));
            end
            1: begin
                n.kind = frq_pkg::KIND_TERM;
                n.reason = 3'($urandom_range(2, 7));
            end
            2: n.kind = frq_pkg::KIND_ACK;
            default: n.kind = KIND_UNUSED;
        endcase
        return n;
    endfunction

    // stimulus
    initial begin
        t_row           rows[$];
        t_row           rw;
        frq_pkg::t_item it;
        t_result        h;
        logic [63:0]    step;
        int             gap;
        bit             quiet;

        drain_wait = 0;
        row_typed = 0;
        row_status = '0;
        i_valid = 1'b0;
        drv = '0;
        release_reset();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: reset state, illegal kinds, fence order, each ack check
        rw.typed = 1;
        it = '0; it.kind = frq_pkg::KIND_ACK;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        it.sord = 64'd1;
        rw.item = it; rw.status = frq_pkg::ST_NOT_NEXT; rows.push_back(rw);
        it = '0; it.kind = KIND_UNUSED; it.fraw = ALL_ONES; it.sord = ALL_ONES;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        it = '0; it.kind = frq_pkg::KIND_POST; it.reason = frq_pkg::REASON_SHUTDOWN;
        it.fraw = ALL_ONES; it.fseq = ALL_ONES;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        it = '0; it.kind = frq_pkg::KIND_TERM; it.reason = 3'd7;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        it = '0; it.kind = frq_pkg::KIND_POST; it.reason = 3'd2;
        it.action = frq_pkg::ACT_CLOSE;
        rw.item = it; rw.status = frq_pkg::ST_POSTED; rows.push_back(rw);
        it.reason = 3'd7; it.action = frq_pkg::ACT_WAIT; it.fraw = 64'd5; it.fseq = 64'd5;
        rw.item = it; rw.status = frq_pkg::ST_POSTED; rows.push_back(rw);
        it.fraw = 64'd4;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        it.fraw = 64'd5; it.fseq = 64'd4;
        rw.item = it; rw.status = frq_pkg::ST_INVALID; rows.push_back(rw);
        // head is ordinal 1, reason 2, close pass, no fences
        it = '0; it.kind = frq_pkg::KIND_ACK; it.sord = 64'd1; it.sgen = 64'd2;
        it.reason = 3'd2;
        rw.item = it; rw.status = frq_pkg::ST_STALE; rows.push_back(rw);
        it.sgen = 64'd1; it.sorigin = 1'b1;
        rw.item = it; rw.status = frq_pkg::ST_NOT_NEXT; rows.push_back(rw);
        it.sorigin = 1'b0; it.completion = 2'd0;
        rw.item = it; rw.status = frq_pkg::ST_INCOMPLETE; rows.push_back(rw);
        it.completion = 2'd3;
        rw.item = it; rw.status = frq_pkg::ST_INCOMPLETE; rows.push_back(rw);
        it.completion = frq_pkg::CMP_CLOSED;
        rw.item = it; rw.status = frq_pkg::ST_ACKED; rows.push_back(rw);
        // head is ordinal 2, reason 7, wait action, fences 5
        it = '0; it.kind = frq_pkg::KIND_ACK; it.sord = 64'd2; it.sgen = 64'd1;
        it.reason = 3'd7;
        it.action = frq_pkg::ACT_WAIT; it.fraw = 64'd5; it.fseq = 64'd5;
        it.completion = frq_pkg::CMP_SUBMITTED; it.craw = 64'd4; it.cseq = ALL_ONES;
        rw.item = it; rw.status = frq_pkg::ST_UNCOVERED; rows.push_back(rw);
        it.craw = ALL_ONES; it.cseq = 64'd4;
        rw.item = it; rw.status = frq_pkg::ST_UNCOVERED; rows.push_back(rw);
        it.cseq = 64'd5; it.completion = frq_pkg::CMP_CLOSED;
        rw.item = it; rw.status = frq_pkg::ST_INCOMPLETE; rows.push_back(rw);
        it.completion = frq_pkg::CMP_SUBMITTED;
        rw.item = it; rw.status = frq_pkg::ST_ACKED; rows.push_back(rw);
        // fill the ring past its depth, checked against the predictor
        rw.typed = 0;
        for (int k = 0; k < RING_DEPTH + 2; k++) begin
            it = '0; it.kind = frq_pkg::KIND_POST;
            it.reason = 3'(2 + k % 6); it.action = 2'(k % 3);
            it.fraw = 64'(5 + k); it.fseq = 64'(6 + k);
            rw.item = it; rows.push_back(rw);
        end

        foreach (rows[k])
            send_item(rows[k].item, $urandom_range(0, 2), rows[k].typed, rows[k].status);

        // random part: ordered traffic first, terminal latch traffic at the end
        quiet = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (n == DRAIN_AT) begin
                i_valid <= 1'b0;
                drain_wait = 1;
                while (pending_results.size() != 0) @(negedge i_clk);
                drain_wait = 0;
            end
            h = head_snapshot();
            gap = quiet ? 0 : $urandom_range(0, 10);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    if (n >= TERM_START && $urandom_range(0, 2) != 0) begin
                        it = '0;
                        it.kind = frq_pkg::KIND_TERM;
                        it.reason = ($urandom_range(0, 9) == 0) ? 3'd5
                                                                : 3'($urandom_range(0, 1));
                        it.action = 2'($urandom_range(0, 3));
                        it.fraw = ($urandom_range(0, 3) == 0) ? ALL_ONES
                                  : sh_wl_raw + 64'($urandom_range(0, 99));
                        it.fseq = {$urandom, $urandom};
                    end else begin
                        it = '0;
                        it.kind = frq_pkg::KIND_POST;
                        it.reason = 3'($urandom_range(2, 7));
                        it.action = 2'($urandom_range(0, 2));
                        step = ($urandom_range(0, 7) == 0) ? {12'd0, $urandom, 20'd0}
                                                           : 64'($urandom_range(0, 1000));
                        it.fraw = ($urandom_range(0, 3) == 0) ? sh_wl_raw : sh_wl_raw + step;
                        it.fseq = sh_wl_seq + 64'($urandom_range(0, 1000));
                    end
                end
                8, 9, 10, 11, 12, 13, 14, 15, 16: begin
                    if (!h.hvalid) begin
                        it = noise_item();
                    end else begin
                        it = ack_of(h, (h.haction == frq_pkg::ACT_CLOSE)
                                       ? 2'($urandom_range(1, 2)) : frq_pkg::CMP_SUBMITTED);
                        case ($urandom_range(0, 14))
                            0: it.sord = it.sord + 64'd1;
                            1: it.sgen = it.sgen + 64'd1;
                            2: it.reason = it.reason ^ 3'd1;
                            3: it.sorigin = ~it.sorigin;
                            4: if (it.fraw != 64'd0) it.craw = it.fraw - 64'd1;
                            5: if (it.fseq != 64'd0) it.cseq = it.fseq - 64'd1;
                            6: it.completion = 2'($urandom_range(0, 3));
                            7: it.action = 2'($urandom_range(0, 3));
                            default: ;
                        endcase
                    end
                end
                default: it = noise_item();
            endcase
            send_item(it, gap, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // wait for the last results, then a short tail
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/frq_pkg.sv
rtl/core/frq_ctrl.sv
rtl/core/frq_dp.sv
rtl/core/fenced_release_queue_unit.sv
tb/tb_fenced_release_queue_unit.sv
